// ----- sv/assert_macros.svh -----
// Concurrent assertion helpers, clocked on aclk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);
`else
`define ASSERT_NOW(label, pre, post, msg)
`define ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ----- sv/mtde_pkg.sv -----
`default_nettype none

package mtde_pkg;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_DELTA  = 2'd1,
        ERR_LENGTH = 2'd2
    } err_code_t;

    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_EOT   = 1'b1;

    localparam int unsigned VLQ_BITS    = 28;
    localparam logic [31:0] VLQ_LIMIT   = 32'h0FFF_FFFF;
    localparam logic [31:0] TOTAL_LIMIT = 32'hFFFF_FFFF;
    localparam logic [31:0] EOT_WORD    = 32'h00FF_2F00;
    localparam int unsigned EOT_BYTES   = 4;
    localparam int unsigned VLQ_MAX     = 4;

endpackage

`default_nettype wire

// ----- sv/midi_track_delta_encoder_core.sv -----
// Track chunk body encoder: sorted events in, SMF track body bytes out.
// Input channel (s_*): one transaction per event (kind 0) or end of track
// (kind 1). Output channel (m_*): one body byte per transaction, m_last on
// the final byte of each input transaction, m_error_code on every byte,
// m_track_length on the last byte of an end-of-track transaction.
// A transaction passes through the input register and then the byte
// shifter before its first byte is presented. Throughput: one byte per
// cycle while m_ready is high; a transaction puts out n bytes: delta bytes plus
// message bytes for an event (1..11 at the default sizes), 4 for end of
// track, 1 for an errored event. The single-byte output port sets this
// figure; the next transaction is loaded in the cycle its predecessor's last
// byte is taken, with no gap.
// An input register holds one transaction while the byte shifter drains.
// Reset (aresetn low, synchronous) empties both stages and clears the
// previous tick, the byte count and the sticky error.
// When m_ready is low the current byte holds, the input register fills,
// and s_ready stays low until the shifter's last byte is taken.
`default_nettype none

`include "assert_macros.svh"

module midi_track_delta_encoder_core #(
    parameter int unsigned TICK_WIDTH      = 32,
    parameter int unsigned MAX_EVENT_BYTES = 7
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_kind,
    input  wire logic [TICK_WIDTH-1:0]        s_tick,
    input  wire logic [2:0]                   s_event_length,
    input  wire logic [8*MAX_EVENT_BYTES-1:0] s_event_bytes,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [7:0]                        m_out_byte,
    output logic                              m_last,
    output logic [1:0]                        m_error_code,
    output logic [31:0]                       m_track_length
);

    localparam int unsigned MSG_W = 8 * MAX_EVENT_BYTES;
    localparam int unsigned BUF_W = 8 * (mtde_pkg::VLQ_MAX + MAX_EVENT_BYTES);
    localparam int unsigned CNT_W = $clog2(mtde_pkg::VLQ_MAX + MAX_EVENT_BYTES + 1);
    localparam logic [TICK_WIDTH:0] DeltaLimit = (TICK_WIDTH + 1)'(mtde_pkg::VLQ_LIMIT);
    localparam logic [3:0] MaxLen = 4'(MAX_EVENT_BYTES);

    logic                  a_valid_reg, a_valid_next;
    logic                  a_kind_reg;
    logic [TICK_WIDTH-1:0] a_tick_reg;
    logic [2:0]            a_len_reg;
    logic [MSG_W-1:0]      a_bytes_reg;

    logic [TICK_WIDTH-1:0] prev_tick_reg, prev_tick_next;
    logic [31:0]           byte_total_reg, byte_total_next;
    logic                  failed_reg, failed_next;

    logic                  ser_valid_reg, ser_valid_next;
    logic [BUF_W-1:0]      buf_reg, buf_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    mtde_pkg::err_code_t   code_reg, code_next;
    logic [31:0]           blen_reg, blen_next;

    logic                  ld;
    logic                  s_take;
    logic [TICK_WIDTH:0]   delta_ext;
    logic                  delta_err;
    logic [27:0]           delta;
    logic [2:0]            groups;
    logic [31:0]           vlq_word;
    logic [3:0]            len_sat;
    logic [CNT_W-1:0]      n_bytes;
    logic [32:0]           sum_event;
    logic [32:0]           sum_eot;
    mtde_pkg::err_code_t   sticky_code;

    assign ld     = a_valid_reg && (!ser_valid_reg || (m_ready && cnt_reg == CNT_W'(1)));
    assign s_ready = !a_valid_reg || ld;
    assign s_take  = s_valid && s_ready;

    assign delta_ext = {1'b0, a_tick_reg} - {1'b0, prev_tick_reg};
    assign delta_err = delta_ext > DeltaLimit;
    assign delta     = delta_ext[27:0];

    always_comb begin
        if (delta[27:7] == '0) begin
            groups = 3'd1;
        end else if (delta[27:14] == '0) begin
            groups = 3'd2;
        end else if (delta[27:21] == '0) begin
            groups = 3'd3;
        end else begin
            groups = 3'd4;
        end
    end

    assign vlq_word = {1'b1, delta[27:21], 1'b1, delta[20:14], 1'b1, delta[13:7],
                       1'b0, delta[6:0]};
    assign len_sat  = ({1'b0, a_len_reg} > MaxLen) ? MaxLen : {1'b0, a_len_reg};
    assign n_bytes  = CNT_W'(groups) + CNT_W'(len_sat);
    assign sum_event = {1'b0, byte_total_reg} + 33'(n_bytes);
    assign sum_eot   = {1'b0, byte_total_reg} + 33'(mtde_pkg::EOT_BYTES);

    always_comb begin
        if (!failed_reg) begin
            sticky_code = mtde_pkg::ERR_NONE;
        end else if (byte_total_reg == mtde_pkg::TOTAL_LIMIT) begin
            sticky_code = mtde_pkg::ERR_LENGTH;
        end else begin
            sticky_code = mtde_pkg::ERR_DELTA;
        end
    end

    always_comb begin
        a_valid_next    = a_valid_reg;
        prev_tick_next  = prev_tick_reg;
        byte_total_next = byte_total_reg;
        failed_next     = failed_reg;
        ser_valid_next  = ser_valid_reg;
        buf_next        = buf_reg;
        cnt_next        = cnt_reg;
        code_next       = code_reg;
        blen_next       = blen_reg;

        if (s_take) begin
            a_valid_next = 1'b1;
        end else if (ld) begin
            a_valid_next = 1'b0;
        end

        if (ld) begin
            ser_valid_next = 1'b1;
            blen_next      = '0;
            if (a_kind_reg == mtde_pkg::KIND_EOT) begin
                buf_next  = {mtde_pkg::EOT_WORD, {MSG_W{1'b0}}};
                cnt_next  = CNT_W'(mtde_pkg::EOT_BYTES);
                code_next = sticky_code;
                blen_next = byte_total_reg;
                if (!failed_reg) begin
                    if (sum_eot[32]) begin
                        code_next = mtde_pkg::ERR_LENGTH;
                        blen_next = mtde_pkg::TOTAL_LIMIT;
                    end else begin
                        blen_next = sum_eot[31:0];
                    end
                end
                prev_tick_next  = '0;
                byte_total_next = '0;
                failed_next     = 1'b0;
            end else if (failed_reg) begin
                buf_next  = '0;
                cnt_next  = CNT_W'(1);
                code_next = sticky_code;
            end else if (delta_err) begin
                buf_next        = '0;
                cnt_next        = CNT_W'(1);
                code_next       = mtde_pkg::ERR_DELTA;
                failed_next     = 1'b1;
                byte_total_next = '0;
            end else if (sum_event[32]) begin
                buf_next        = '0;
                cnt_next        = CNT_W'(1);
                code_next       = mtde_pkg::ERR_LENGTH;
                failed_next     = 1'b1;
                byte_total_next = mtde_pkg::TOTAL_LIMIT;
            end else begin
                buf_next        = {vlq_word, a_bytes_reg} << {3'd4 - groups, 3'b000};
                cnt_next        = n_bytes;
                code_next       = mtde_pkg::ERR_NONE;
                byte_total_next = sum_event[31:0];
                prev_tick_next  = a_tick_reg;
            end
        end else if (ser_valid_reg && m_ready) begin
            if (cnt_reg == CNT_W'(1)) begin
                ser_valid_next = 1'b0;
            end else begin
                buf_next = buf_reg << 8;
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg    <= 1'b0;
            prev_tick_reg  <= '0;
            byte_total_reg <= '0;
            failed_reg     <= 1'b0;
            ser_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            a_valid_reg    <= a_valid_next;
            prev_tick_reg  <= prev_tick_next;
            byte_total_reg <= byte_total_next;
            failed_reg     <= failed_next;
            ser_valid_reg  <= ser_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            a_kind_reg  <= s_kind;
            a_tick_reg  <= s_tick;
            a_len_reg   <= s_event_length;
            a_bytes_reg <= s_event_bytes;
        end
        buf_reg  <= buf_next;
        code_reg <= code_next;
        blen_reg <= blen_next;
    end

    assign m_valid        = ser_valid_reg;
    assign m_out_byte     = buf_reg[BUF_W-1 -: 8];
    assign m_last         = cnt_reg == CNT_W'(1);
    assign m_error_code   = code_reg;
    assign m_track_length = m_last ? blen_reg : '0;

    `ASSERT_NOW(a_busy_has_bytes, ser_valid_reg, cnt_reg != '0, "shifter valid with no bytes")
    `ASSERT_NEXT(a_hold_pending, a_valid_reg && !ld, a_valid_reg, "pending transaction dropped")
    `ASSERT_NEXT(a_eot_clears, ld && a_kind_reg == mtde_pkg::KIND_EOT,
        prev_tick_reg == '0 && byte_total_reg == '0 && !failed_reg,
        "state not cleared after end of track")
    `ASSERT_NOW(a_error_single,
        m_valid && m_error_code != mtde_pkg::ERR_NONE && !failed_reg,
        m_last || blen_reg != '0 || cnt_reg <= CNT_W'(mtde_pkg::EOT_BYTES),
        "error result longer than expected")

endmodule

`default_nettype wire
